/* hw/rtl/assert_macros.svh */
// Assertion macros used by the checker file of the changer bus slave.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define CACBS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("cacbs assertion failed");

// Check that a condition never holds outside reset
`define CACBS_NEVER(label, clk, rst_n, cond) \
    `CACBS_ASSERT(label, clk, rst_n, !(cond))

`endif

/* hw/rtl/cacbs_pkg.sv */
// Types and constants of the changer bus slave: channel payloads, command
// codes, head-unit command patterns and response tables. Depends on nothing.
package cacbs_pkg;

    // One bus clock edge with the sampled data level
    typedef struct packed {
        logic edge_rising;
        logic data_bit;
    } t_edge;

    // One result per edge
    typedef struct packed {
        logic       drive_enable;
        logic       drive_level;
        logic       byte_valid;
        logic [7:0] byte_value;
        logic [2:0] event_code;
        logic [7:0] track_number;
        logic       stopped;
    } t_result;

    // Pending command codes
    localparam logic [3:0] CMD_NONE       = 4'd0;
    localparam logic [3:0] CMD_INIT       = 4'd1;
    localparam logic [3:0] CMD_CART_INFO  = 4'd2;
    localparam logic [3:0] CMD_PLAY       = 4'd3;
    localparam logic [3:0] CMD_POWER_UP   = 4'd4;
    localparam logic [3:0] CMD_POWER_DOWN = 4'd5;
    localparam logic [3:0] CMD_NEXT       = 4'd6;
    localparam logic [3:0] CMD_PREV       = 4'd7;
    localparam logic [3:0] CMD_FF         = 4'd8;
    localparam logic [3:0] CMD_FR         = 4'd9;
    localparam logic [3:0] CMD_SCAN       = 4'd10;
    localparam logic [3:0] CMD_RANDOM     = 4'd11;

    // Host event codes
    localparam logic [2:0] EVT_NONE     = 3'd0;
    localparam logic [2:0] EVT_NEXT     = 3'd1;
    localparam logic [2:0] EVT_PREV     = 3'd2;
    localparam logic [2:0] EVT_VOL_UP   = 3'd3;
    localparam logic [2:0] EVT_VOL_DOWN = 3'd4;
    localparam logic [2:0] EVT_SCAN     = 3'd5;
    localparam logic [2:0] EVT_PLAY     = 3'd6;

    // Reset values and fixed bytes
    localparam logic [7:0] DEVICE_ID_RESET = 8'hE8;
    localparam logic [7:0] IDLE_BYTE       = 8'hFF;
    localparam logic [7:0] TRACK_FIRST     = 8'h01;
    localparam logic [7:0] TRACK_LAST      = 8'h99;
    localparam logic [7:0] STATUS_PLAYING  = 8'h08;
    localparam logic [7:0] STATUS_STOPPED  = 8'h02;
    localparam logic [7:0] POWER_ACK       = 8'h00;

    // Response lengths
    localparam logic [3:0] CART_LEN = 4'd6;
    localparam logic [3:0] PLAY_LEN = 4'd9;
    localparam logic [3:0] PLAY_IDX_STATUS = 4'd1;
    localparam logic [3:0] PLAY_IDX_TRACK  = 4'd5;

    // Command patterns, oldest byte first, ending at the newest byte
    localparam logic [23:0] PAT_INIT       = 24'h071AEE;
    localparam logic [15:0] PAT_CART_INFO  = 16'h1EEF;
    localparam logic [31:0] PAT_PLAY       = 32'h1BE00108;
    localparam logic [15:0] PAT_POWER_UP   = 16'h192F;
    localparam logic [15:0] PAT_POWER_DOWN = 16'h1922;
    localparam logic [31:0] PAT_NEXT       = 32'h1B2D4001;
    localparam logic [31:0] PAT_PREV       = 32'h1B2D0001;
    localparam logic [15:0] PAT_FF         = 16'h1929;
    localparam logic [15:0] PAT_FR         = 16'h1926;
    localparam logic [15:0] PAT_SCAN       = 16'h192E;
    localparam logic [15:0] PAT_RANDOM     = 16'h1952;

    // Cart info bytes
    function automatic logic [7:0] cart_byte(input logic [3:0] idx);
        logic [7:0] b;
        unique case (idx)
            4'd1:    b = 8'h0F;
            4'd2:    b = 8'hFF;
            4'd3:    b = 8'h4A;
            4'd4:    b = 8'hFC;
            4'd5:    b = 8'hFF;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // Play info bytes before status and track are patched in
    function automatic logic [7:0] play_base_byte(input logic [3:0] idx);
        logic [7:0] b;
        unique case (idx)
            4'd1:    b = 8'h02;
            4'd3:    b = 8'h01;
            4'd4:    b = 8'h80;
            4'd5:    b = 8'h01;
            4'd6:    b = 8'hFF;
            4'd7:    b = 8'h06;
            4'd8:    b = 8'h06;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

/* hw/rtl/cacbs_chan_if.sv */
// Valid/ready channel carrying one payload per transaction.
// Depends on nothing; the payload type is set per instance.
interface cacbs_chan_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* hw/rtl/car_audio_changer_bus_slave_unit.sv */
// Top level of the changer bus slave: edge decoder, byte window, command
// matcher and responder. Depends on cacbs_pkg and cacbs_chan_if.

// Each input transaction is one bus clock edge with the sampled data level;
// it yields exactly one result transaction from a result register. An edge
// is taken every cycle as long as the result register is empty or its
// result is taken in the same cycle, so the block sustains one edge per clock;
// the only limit is the result register's handshake. The device id register
// may be written only while no edge is in flight.
module car_audio_changer_bus_slave_unit #(
    parameter int WINDOW_BYTES = 6
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cacbs_chan_if.sink   i_edge,
    cacbs_chan_if.source o_result,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata
);

    logic [7:0] r_device_id;
    logic [7:0] r_window [WINDOW_BYTES];
    logic [7:0] n_window [WINDOW_BYTES];
    logic [7:0] r_rx_shift, n_rx_shift;
    logic [2:0] r_rx_idx, n_rx_idx;
    logic [2:0] r_tx_idx, n_tx_idx;
    logic [7:0] r_tx_byte, n_tx_byte;
    logic       r_sending, n_sending;
    logic [3:0] r_pending, n_pending;
    logic [3:0] r_resp_idx, n_resp_idx;
    logic       r_stopped, n_stopped;
    logic [7:0] r_play_status, n_play_status;
    logic [7:0] r_track, n_track;
    logic [2:0] r_event, n_event;
    logic       r_drive_on, n_drive_on;
    logic       r_drive_lvl, n_drive_lvl;
    logic       r_out_valid;
    cacbs_pkg::t_result r_out, n_out;

    logic       w_accept;
    logic       w_push;
    logic [7:0] w_push_byte;
    logic [3:0] w_match;
    logic [3:0] w_code;
    logic [3:0] w_idx;
    logic [3:0] w_idx_next;
    logic [3:0] w_len;
    logic [7:0] w_resp_byte;
    logic [7:0] w_inc;
    logic [7:0] w_dec;
    logic [7:0] n_window_last;
    logic [15:0] w_tail2;
    logic [23:0] w_tail3;
    logic [31:0] w_tail4;

    // Take an edge when the result register is free or being emptied
    assign i_edge.ready = !r_out_valid || o_result.ready;
    assign w_accept     = i_edge.valid && i_edge.ready;

    assign o_result.valid   = r_out_valid;
    assign o_result.payload = r_out;

    // Shift in on rising edges, shift out on falling edges
    always_comb begin
        n_rx_shift  = r_rx_shift;
        n_rx_idx    = r_rx_idx;
        n_tx_idx    = r_tx_idx;
        n_drive_on  = r_drive_on;
        n_drive_lvl = r_drive_lvl;
        w_push      = 1'b0;
        w_push_byte = r_tx_byte;
        if (i_edge.payload.edge_rising) begin
            if (!r_sending) begin
                n_rx_shift[r_rx_idx] = i_edge.payload.data_bit;
                if (r_rx_idx == 3'd0) begin
                    n_rx_idx    = 3'd7;
                    w_push      = 1'b1;
                    w_push_byte = n_rx_shift;
                end else begin
                    n_rx_idx = r_rx_idx - 3'd1;
                end
            end
        end else begin
            if (r_sending) begin
                n_drive_on  = 1'b1;
                n_drive_lvl = r_tx_byte[r_tx_idx];
                if (r_tx_idx == 3'd0) begin
                    n_tx_idx = 3'd7;
                    w_push   = 1'b1;
                end else begin
                    n_tx_idx = r_tx_idx - 3'd1;
                end
            end else begin
                n_drive_on  = 1'b0;
                n_drive_lvl = 1'b0;
            end
        end
    end

    // Advance the byte window on a completed byte
    always_comb begin
        for (int k = 0; k < WINDOW_BYTES - 1; k++) begin
            n_window[k] = w_push ? r_window[k + 1] : r_window[k];
        end
        n_window[WINDOW_BYTES - 1] = w_push ? w_push_byte : r_window[WINDOW_BYTES - 1];
    end

    assign n_window_last = n_window[WINDOW_BYTES - 1];
    assign w_tail2 = {n_window[WINDOW_BYTES - 2], n_window[WINDOW_BYTES - 1]};
    assign w_tail3 = {n_window[WINDOW_BYTES - 3], w_tail2};
    assign w_tail4 = {n_window[WINDOW_BYTES - 4], w_tail3};

    // Match the window tail against the command patterns, first hit wins
    always_comb begin
        priority if (w_tail3 == cacbs_pkg::PAT_INIT)       w_match = cacbs_pkg::CMD_INIT;
        else if (w_tail2 == cacbs_pkg::PAT_CART_INFO)      w_match = cacbs_pkg::CMD_CART_INFO;
        else if (w_tail4 == cacbs_pkg::PAT_PLAY)           w_match = cacbs_pkg::CMD_PLAY;
        else if (w_tail2 == cacbs_pkg::PAT_POWER_UP)       w_match = cacbs_pkg::CMD_POWER_UP;
        else if (w_tail2 == cacbs_pkg::PAT_POWER_DOWN)     w_match = cacbs_pkg::CMD_POWER_DOWN;
        else if (w_tail4 == cacbs_pkg::PAT_NEXT)           w_match = cacbs_pkg::CMD_NEXT;
        else if (w_tail4 == cacbs_pkg::PAT_PREV)           w_match = cacbs_pkg::CMD_PREV;
        else if (w_tail2 == cacbs_pkg::PAT_FF)             w_match = cacbs_pkg::CMD_FF;
        else if (w_tail2 == cacbs_pkg::PAT_FR)             w_match = cacbs_pkg::CMD_FR;
        else if (w_tail2 == cacbs_pkg::PAT_SCAN)           w_match = cacbs_pkg::CMD_SCAN;
        else if (w_tail2 == cacbs_pkg::PAT_RANDOM)         w_match = cacbs_pkg::CMD_RANDOM;
        else                                               w_match = cacbs_pkg::CMD_NONE;
    end

    // Serve a pending command before looking for a new one
    assign w_code = (r_pending != cacbs_pkg::CMD_NONE) ? r_pending : w_match;

    // Pick the next cart or play info byte
    assign w_len      = (w_code == cacbs_pkg::CMD_CART_INFO) ?
                        cacbs_pkg::CART_LEN : cacbs_pkg::PLAY_LEN;
    assign w_idx      = (r_resp_idx >= w_len) ? 4'd0 : r_resp_idx;
    assign w_idx_next = w_idx + 4'd1;

    always_comb begin
        if (w_code == cacbs_pkg::CMD_CART_INFO) begin
            w_resp_byte = cacbs_pkg::cart_byte(w_idx);
        end else if (w_idx == cacbs_pkg::PLAY_IDX_STATUS) begin
            w_resp_byte = r_play_status;
        end else if (w_idx == cacbs_pkg::PLAY_IDX_TRACK) begin
            w_resp_byte = r_track;
        end else begin
            w_resp_byte = cacbs_pkg::play_base_byte(w_idx);
        end
    end

    // Step the BCD track number with wrap at both ends
    always_comb begin
        w_inc = r_track + 8'd1;
        if (w_inc > cacbs_pkg::TRACK_LAST) w_inc = cacbs_pkg::TRACK_FIRST;
        if (w_inc[3:0] > 4'd9) w_inc = w_inc + 8'd6;
        w_dec = r_track - 8'd1;
        if (w_dec < cacbs_pkg::TRACK_FIRST) w_dec = cacbs_pkg::TRACK_LAST;
        if (w_dec[3:0] == 4'hF) w_dec = w_dec - 8'd6;
    end

    // Answer the command when a byte completes
    always_comb begin
        n_sending     = r_sending;
        n_tx_byte     = r_tx_byte;
        n_pending     = r_pending;
        n_resp_idx    = r_resp_idx;
        n_stopped     = r_stopped;
        n_play_status = r_play_status;
        n_track       = r_track;
        n_event       = r_event;
        if (!i_edge.payload.edge_rising && r_sending && r_tx_idx == 3'd0) begin
            n_sending = 1'b0;
        end
        if (w_push) begin
            n_pending = cacbs_pkg::CMD_NONE;
            unique case (w_code)
                cacbs_pkg::CMD_NONE: begin
                end
                cacbs_pkg::CMD_INIT: begin
                    if (n_window_last == r_device_id) begin
                        n_sending = 1'b1;
                        n_tx_byte = r_device_id;
                    end else begin
                        n_pending = cacbs_pkg::CMD_INIT;
                    end
                end
                cacbs_pkg::CMD_CART_INFO, cacbs_pkg::CMD_PLAY: begin
                    n_sending = 1'b1;
                    n_tx_byte = w_resp_byte;
                    if (w_idx_next >= w_len) begin
                        n_resp_idx = 4'd0;
                    end else begin
                        n_pending  = w_code;
                        n_resp_idx = w_idx_next;
                    end
                end
                cacbs_pkg::CMD_POWER_UP: begin
                    n_sending = 1'b1;
                    n_tx_byte = cacbs_pkg::POWER_ACK;
                    if (r_stopped) begin
                        n_play_status = cacbs_pkg::STATUS_PLAYING;
                        n_stopped     = 1'b0;
                    end
                end
                cacbs_pkg::CMD_POWER_DOWN: begin
                    n_sending     = 1'b1;
                    n_tx_byte     = cacbs_pkg::POWER_ACK;
                    n_play_status = cacbs_pkg::STATUS_STOPPED;
                    n_stopped     = 1'b1;
                end
                cacbs_pkg::CMD_NEXT: begin
                    n_track = w_inc;
                    n_event = cacbs_pkg::EVT_NEXT;
                end
                cacbs_pkg::CMD_PREV: begin
                    n_track = w_dec;
                    n_event = cacbs_pkg::EVT_PREV;
                end
                cacbs_pkg::CMD_FF:     n_event = cacbs_pkg::EVT_VOL_UP;
                cacbs_pkg::CMD_FR:     n_event = cacbs_pkg::EVT_VOL_DOWN;
                cacbs_pkg::CMD_SCAN:   n_event = cacbs_pkg::EVT_SCAN;
                cacbs_pkg::CMD_RANDOM: n_event = cacbs_pkg::EVT_PLAY;
                default: begin
                end
            endcase
        end
    end

    // Assemble the result of this edge
    always_comb begin
        n_out.drive_enable = n_drive_on;
        n_out.drive_level  = n_drive_on & n_drive_lvl;
        n_out.byte_valid   = w_push;
        n_out.byte_value   = w_push ? w_push_byte : 8'h00;
        n_out.event_code   = n_event;
        n_out.track_number = n_track;
        n_out.stopped      = n_stopped;
    end

    // Hold the device id
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_id <= cacbs_pkg::DEVICE_ID_RESET;
        end else if (i_cfg_we) begin
            r_device_id <= i_cfg_wdata;
        end
    end

    // Update the bus state on each accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WINDOW_BYTES; k++) begin
                r_window[k] <= cacbs_pkg::IDLE_BYTE;
            end
            r_rx_shift    <= 8'h00;
            r_rx_idx      <= 3'd7;
            r_tx_idx      <= 3'd7;
            r_tx_byte     <= 8'h00;
            r_sending     <= 1'b0;
            r_pending     <= cacbs_pkg::CMD_NONE;
            r_resp_idx    <= 4'd0;
            r_stopped     <= 1'b0;
            r_play_status <= cacbs_pkg::STATUS_STOPPED;
            r_track       <= cacbs_pkg::TRACK_FIRST;
            r_event       <= cacbs_pkg::EVT_NONE;
            r_drive_on    <= 1'b0;
            r_drive_lvl   <= 1'b0;
        end else if (w_accept) begin
            r_window      <= n_window;
            r_rx_shift    <= n_rx_shift;
            r_rx_idx      <= n_rx_idx;
            r_tx_idx      <= n_tx_idx;
            r_tx_byte     <= n_tx_byte;
            r_sending     <= n_sending;
            r_pending     <= n_pending;
            r_resp_idx    <= n_resp_idx;
            r_stopped     <= n_stopped;
            r_play_status <= n_play_status;
            r_track       <= n_track;
            r_event       <= n_event;
            r_drive_on    <= n_drive_on;
            r_drive_lvl   <= n_drive_lvl;
        end
    end

    // Load the result register, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= n_out;
        end
    end

endmodule

/* hw/rtl/cacbs_checker.sv */
// Port-level checks of the changer bus slave, bound to its top level.
// Depends on cacbs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cacbs_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input cacbs_pkg::t_result i_out
);

    // Hold a stalled result
    `CACBS_ASSERT(a_stall_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out))

    // Drive a high level only while driving the line
    `CACBS_NEVER(a_level_released, i_clk, i_rst_n, i_out_valid && i_out.drive_level && !i_out.drive_enable)

    // Keep the track number a BCD value from 01 to 99
    `CACBS_ASSERT(a_track_bcd, i_clk, i_rst_n, i_out_valid |-> i_out.track_number[3:0] <= 4'd9 && i_out.track_number[7:4] <= 4'd9 && i_out.track_number != 8'h00)

    // Show no byte value without a completed byte
    `CACBS_NEVER(a_byte_idle, i_clk, i_rst_n, i_out_valid && !i_out.byte_valid && i_out.byte_value != 8'h00)

endmodule

bind car_audio_changer_bus_slave_unit cacbs_checker u_cacbs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out       (o_result.payload)
);

/* test/tb_car_audio_changer_bus_slave_unit.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the changer bus slave, fed one bus clock edge per transaction.
// Depends on cacbs_pkg, cacbs_chan_if and car_audio_changer_bus_slave_unit.
module tb_car_audio_changer_bus_slave_unit;

    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 6;
    localparam int WIN            = 6;
    localparam int RANDOM_EDGES   = 700;
    localparam int PHASES         = 4;
    localparam int LONG_HOLD      = 60;
    localparam int SETTLE         = 4;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DIR_ROWS       = 33;

    // Response tables, first byte sent in the top byte
    localparam logic [47:0] CART_INFO_BYTES = 48'h00_0F_FF_4A_FC_FF;
    localparam logic [71:0] PLAY_INFO_BYTES = 72'h00_02_00_01_80_01_FF_06_06;

    // One host byte of the directed part; evt/trk/stp apply only when typed is set
    typedef struct packed {
        logic [7:0] data;
        logic       typed;
        logic [2:0] evt;
        logic [7:0] trk;
        logic       stp;
    } t_dir_row;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_we;
    logic [7:0] cfg_wdata;

    cacbs_chan_if #(.t_payload(cacbs_pkg::t_edge))   edge_if ();
    cacbs_chan_if #(.t_payload(cacbs_pkg::t_result)) result_if ();

    car_audio_changer_bus_slave_unit DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_edge      (edge_if),
        .o_result    (result_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    // Bus model state
    logic [7:0] win [WIN];
    logic [7:0] rx_sr;
    logic [2:0] rx_idx;
    logic [2:0] tx_idx;
    logic [7:0] tx_sr;
    logic       tx_active;
    logic [3:0] pend_cmd;
    logic [3:0] resp_idx;
    logic       stop_flag;
    logic [7:0] status_byte;
    logic [7:0] track;
    logic [2:0] host_evt;
    logic       drv_on;
    logic       drv_lvl;
    logic [7:0] dev_id;

    cacbs_pkg::t_result exp_results [$];
    int      fail_cnt      = 0;
    int      edges_done    = 0;
    int      idle_cycles   = 0;
    int      hold_cnt      = 0;
    bit      no_idle       = 1'b0;
    bit      long_hold_req = 1'b0;

    // Directed host bytes: every command once, init held off by other traffic,
    // track wrap in both directions
    t_dir_row dir_rows [DIR_ROWS] = '{
        '{8'h00, 1'b1, cacbs_pkg::EVT_NONE,     8'h01, 1'b0},
        '{8'h07, 1'b0, cacbs_pkg::EVT_NONE,     8'h00, 1'b0},
        '{8'h1A, 1'b0, cacbs_pkg::EVT_NONE,     8'h00, 1'b0},
        '{8'hEE, 1'b0, cacbs_pkg::EVT_NONE,     8'h00, 1'b0},
        '{8'h1E, 1'b0, cacbs_pkg::EVT_NONE,     8'h00, 1'b0},
        '{8'hEF, 1'b0, cacbs_pkg::EVT_NONE,     8'h00, 1'b0},
        '{8'hE8, 1'b1, cacbs_pkg::EVT_NONE,     8'h01, 1'b0},
        '{8'h1E, 1'b0, cacbs_pkg::EVT_NONE,     8'h00, 1'b0},
        '{8'hEF, 1'b0, cacbs_pkg::EVT_NONE,     8'h00, 1'b0},
        '{8'h1B, 1'b0, cacbs_pkg::EVT_NONE,     8'h00, 1'b0},
        '{8'hE0, 1'b0, cacbs_pkg::EVT_NONE,     8'h00, 1'b0},
        '{8'h01, 1'b0, cacbs_pkg::EVT_NONE,     8'h00, 1'b0},
        '{8'h08, 1'b0, cacbs_pkg::EVT_NONE,     8'h00, 1'b0},
        '{8'h19, 1'b0, cacbs_pkg::EVT_NONE,     8'h00, 1'b0},
        '{8'h22, 1'b1, cacbs_pkg::EVT_NONE,     8'h01, 1'b1},
        '{8'h19, 1'b0, cacbs_pkg::EVT_NONE,     8'h00, 1'b0},
        '{8'h2F, 1'b1, cacbs_pkg::EVT_NONE,     8'h01, 1'b0},
        '{8'h1B, 1'b0, cacbs_pkg::EVT_NONE,     8'h00, 1'b0},
        '{8'h2D, 1'b0, cacbs_pkg::EVT_NONE,     8'h00, 1'b0},
        '{8'h00, 1'b0, cacbs_pkg::EVT_NONE,     8'h00, 1'b0},
        '{8'h01, 1'b1, cacbs_pkg::EVT_PREV,     8'h99, 1'b0},
        '{8'h1B, 1'b0, cacbs_pkg::EVT_NONE,     8'h00, 1'b0},
        '{8'h2D, 1'b0, cacbs_pkg::EVT_NONE,     8'h00, 1'b0},
        '{8'h40, 1'b0, cacbs_pkg::EVT_NONE,     8'h00, 1'b0},
        '{8'h01, 1'b1, cacbs_pkg::EVT_NEXT,     8'h01, 1'b0},
        '{8'h19, 1'b0, cacbs_pkg::EVT_NONE,     8'h00, 1'b0},
        '{8'h29, 1'b1, cacbs_pkg::EVT_VOL_UP,   8'h01, 1'b0},
        '{8'h19, 1'b0, cacbs_pkg::EVT_NONE,     8'h00, 1'b0},
        '{8'h26, 1'b1, cacbs_pkg::EVT_VOL_DOWN, 8'h01, 1'b0},
        '{8'h19, 1'b0, cacbs_pkg::EVT_NONE,     8'h00, 1'b0},
        '{8'h2E, 1'b1, cacbs_pkg::EVT_SCAN,     8'h01, 1'b0},
        '{8'h19, 1'b0, cacbs_pkg::EVT_NONE,     8'h00, 1'b0},
        '{8'h52, 1'b1, cacbs_pkg::EVT_PLAY,     8'h01, 1'b0}
    };

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ---------------------------------------------------------------- model

    // Compare the newest window bytes with a command pattern, oldest byte on top
    function automatic bit tail_is(input logic [31:0] pat, input int len);
        for (int i = 0; i < len; i++)
            if (win[WIN - len + i] != pat[8 * (len - 1 - i) +: 8]) return 1'b0;
        return 1'b1;
    endfunction

    // Serve the pending command: load a response byte or apply the button action
    function automatic void answer_pending();
        logic [3:0] n;
        logic [3:0] len;
        case (pend_cmd)
            cacbs_pkg::CMD_NONE: ;
            cacbs_pkg::CMD_INIT: begin
                if (win[WIN - 1] == dev_id) begin
                    tx_active = 1'b1;
                    tx_sr     = dev_id;
                    pend_cmd  = cacbs_pkg::CMD_NONE;
                end
            end
            cacbs_pkg::CMD_CART_INFO, cacbs_pkg::CMD_PLAY: begin
                len = (pend_cmd == cacbs_pkg::CMD_CART_INFO) ? 4'd6 : 4'd9;
                n   = (resp_idx >= len) ? 4'd0 : resp_idx;
                tx_active = 1'b1;
                if (pend_cmd == cacbs_pkg::CMD_CART_INFO)
                    tx_sr = CART_INFO_BYTES[8 * (5 - int'(n)) +: 8];
                else if (n == 4'd1)
                    tx_sr = status_byte;
                else if (n == 4'd5)
                    tx_sr = track;
                else
                    tx_sr = PLAY_INFO_BYTES[8 * (8 - int'(n)) +: 8];
                n = n + 4'd1;
                if (n >= len) begin
                    pend_cmd = cacbs_pkg::CMD_NONE;
                    n        = 4'd0;
                end
                resp_idx = n;
            end
            cacbs_pkg::CMD_POWER_UP: begin
                tx_active = 1'b1;
                tx_sr     = cacbs_pkg::POWER_ACK;
                if (stop_flag) begin
                    status_byte = cacbs_pkg::STATUS_PLAYING;
                    stop_flag   = 1'b0;
                end
                pend_cmd = cacbs_pkg::CMD_NONE;
            end
            cacbs_pkg::CMD_POWER_DOWN: begin
                tx_active   = 1'b1;
                tx_sr       = cacbs_pkg::POWER_ACK;
                status_byte = cacbs_pkg::STATUS_STOPPED;
                stop_flag   = 1'b1;
                pend_cmd    = cacbs_pkg::CMD_NONE;
            end
            cacbs_pkg::CMD_NEXT: begin
                track = track + 8'd1;
                if (track > cacbs_pkg::TRACK_LAST) track = cacbs_pkg::TRACK_FIRST;
                if (track[3:0] > 4'd9) track = track + 8'd6;
                host_evt = cacbs_pkg::EVT_NEXT;
                pend_cmd = cacbs_pkg::CMD_NONE;
            end
            cacbs_pkg::CMD_PREV: begin
                track = track - 8'd1;
                if (track < cacbs_pkg::TRACK_FIRST) track = cacbs_pkg::TRACK_LAST;
                if (track[3:0] == 4'hF) track = track - 8'd6;
                host_evt = cacbs_pkg::EVT_PREV;
                pend_cmd = cacbs_pkg::CMD_NONE;
            end
            cacbs_pkg::CMD_FF: begin
                host_evt = cacbs_pkg::EVT_VOL_UP;
                pend_cmd = cacbs_pkg::CMD_NONE;
            end
            cacbs_pkg::CMD_FR: begin
                host_evt = cacbs_pkg::EVT_VOL_DOWN;
                pend_cmd = cacbs_pkg::CMD_NONE;
            end
            cacbs_pkg::CMD_SCAN: begin
                host_evt = cacbs_pkg::EVT_SCAN;
                pend_cmd = cacbs_pkg::CMD_NONE;
            end
            cacbs_pkg::CMD_RANDOM: begin
                host_evt = cacbs_pkg::EVT_PLAY;
                pend_cmd = cacbs_pkg::CMD_NONE;
            end
            default: pend_cmd = cacbs_pkg::CMD_NONE;
        endcase
    endfunction

    // Look up the window tail in command table order, first hit wins
    function automatic void match_commands();
        if (tail_is(32'(cacbs_pkg::PAT_INIT), 3))
            pend_cmd = cacbs_pkg::CMD_INIT;
        else if (tail_is(32'(cacbs_pkg::PAT_CART_INFO), 2))
            pend_cmd = cacbs_pkg::CMD_CART_INFO;
        else if (tail_is(cacbs_pkg::PAT_PLAY, 4))
            pend_cmd = cacbs_pkg::CMD_PLAY;
        else if (tail_is(32'(cacbs_pkg::PAT_POWER_UP), 2))
            pend_cmd = cacbs_pkg::CMD_POWER_UP;
        else if (tail_is(32'(cacbs_pkg::PAT_POWER_DOWN), 2))
            pend_cmd = cacbs_pkg::CMD_POWER_DOWN;
        else if (tail_is(cacbs_pkg::PAT_NEXT, 4))
            pend_cmd = cacbs_pkg::CMD_NEXT;
        else if (tail_is(cacbs_pkg::PAT_PREV, 4))
            pend_cmd = cacbs_pkg::CMD_PREV;
        else if (tail_is(32'(cacbs_pkg::PAT_FF), 2))
            pend_cmd = cacbs_pkg::CMD_FF;
        else if (tail_is(32'(cacbs_pkg::PAT_FR), 2))
            pend_cmd = cacbs_pkg::CMD_FR;
        else if (tail_is(32'(cacbs_pkg::PAT_SCAN), 2))
            pend_cmd = cacbs_pkg::CMD_SCAN;
        else if (tail_is(32'(cacbs_pkg::PAT_RANDOM), 2))
            pend_cmd = cacbs_pkg::CMD_RANDOM;
        else
            pend_cmd = cacbs_pkg::CMD_NONE;
        if (pend_cmd != cacbs_pkg::CMD_NONE) answer_pending();
    endfunction

    // Push a completed byte into the window, then answer or match
    function automatic void shift_in_byte(input logic [7:0] b);
        for (int i = 0; i < WIN - 1; i++) win[i] = win[i + 1];
        win[WIN - 1] = b;
        if (pend_cmd != cacbs_pkg::CMD_NONE) answer_pending();
        else match_commands();
    endfunction

    // Advance the bus model by one edge and return the result it should produce
    function automatic cacbs_pkg::t_result predict_edge(input logic rising, input logic lvl);
        cacbs_pkg::t_result r;
        logic [7:0]         done_byte;
        r = '0;
        if (rising) begin
            // shift in while receiving; rising edges during a send are ignored
            if (!tx_active) begin
                rx_sr[rx_idx] = lvl;
                if (rx_idx == 3'd0) begin
                    rx_idx      = 3'd7;
                    r.byte_valid = 1'b1;
                    r.byte_value = rx_sr;
                    shift_in_byte(rx_sr);
                end else begin
                    rx_idx = rx_idx - 3'd1;
                end
            end
        end else if (tx_active) begin
            // drive the next bit; the line stays driven after bit 0
            drv_on  = 1'b1;
            drv_lvl = tx_sr[tx_idx];
            if (tx_idx == 3'd0) begin
                done_byte    = tx_sr;
                tx_idx       = 3'd7;
                tx_active    = 1'b0;
                r.byte_valid = 1'b1;
                r.byte_value = done_byte;
                shift_in_byte(done_byte);
            end else begin
                tx_idx = tx_idx - 3'd1;
            end
        end else begin
            drv_on  = 1'b0;
            drv_lvl = 1'b0;
        end
        r.drive_enable = drv_on;
        r.drive_level  = drv_on ? drv_lvl : 1'b0;
        r.event_code   = host_evt;
        r.track_number = track;
        r.stopped      = stop_flag;
        return r;
    endfunction

    // ------------------------------------------------------------ stimulus

    // Offer one edge, wait for the transaction, record what it must produce
    task automatic drive_edge(input logic rising, input logic lvl, input bit use_typed,
                              input cacbs_pkg::t_result typed_res);
        cacbs_pkg::t_result predicted;
        int                 gap;
        @(negedge clk);
        if (!no_idle && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 3);
            edge_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        edge_if.valid   <= 1'b1;
        edge_if.payload <= cacbs_pkg::t_edge'{edge_rising: rising, data_bit: lvl};
        do @(posedge clk); while (!(edge_if.valid && edge_if.ready));
        if (!(rising && tx_active)) edges_done++;
        predicted = predict_edge(rising, lvl);
        exp_results.push_back(use_typed ? typed_res : predicted);
    endtask

    // Clock out any response and realign the receiver to a byte boundary
    task automatic flush_bus();
        while (tx_active || rx_idx != 3'd7) begin
            drive_edge(1'b0, 1'($urandom_range(0, 1)), 1'b0, '0);
            if (tx_active || rx_idx != 3'd7)
                drive_edge(1'b1, 1'($urandom_range(0, 1)), 1'b0, '0);
        end
    endtask

    // Send one byte from the head unit, MSB first, a falling then a rising edge per bit
    task automatic send_host_byte(input logic [7:0] b, input bit use_typed,
                                  input cacbs_pkg::t_result typed_res);
        flush_bus();
        for (int i = 7; i >= 0; i--) begin
            drive_edge(1'b0, 1'($urandom_range(0, 1)), 1'b0, '0);
            drive_edge(1'b1, b[i], use_typed && i == 0, typed_res);
        end
    endtask

    // Send a command pattern; a broken one stops short and ends in a random byte
    task automatic send_command(input logic [3:0] cmd, input bit broken);
        logic [31:0] pat;
        int          len;
        int          upto;
        case (cmd)
            cacbs_pkg::CMD_INIT: begin
                pat = 32'(cacbs_pkg::PAT_INIT);       len = 3;
            end
            cacbs_pkg::CMD_CART_INFO: begin
                pat = 32'(cacbs_pkg::PAT_CART_INFO);  len = 2;
            end
            cacbs_pkg::CMD_PLAY: begin
                pat = cacbs_pkg::PAT_PLAY;            len = 4;
            end
            cacbs_pkg::CMD_POWER_UP: begin
                pat = 32'(cacbs_pkg::PAT_POWER_UP);   len = 2;
            end
            cacbs_pkg::CMD_POWER_DOWN: begin
                pat = 32'(cacbs_pkg::PAT_POWER_DOWN); len = 2;
            end
            cacbs_pkg::CMD_NEXT: begin
                pat = cacbs_pkg::PAT_NEXT;            len = 4;
            end
            cacbs_pkg::CMD_PREV: begin
                pat = cacbs_pkg::PAT_PREV;            len = 4;
            end
            cacbs_pkg::CMD_FF: begin
                pat = 32'(cacbs_pkg::PAT_FF);         len = 2;
            end
            cacbs_pkg::CMD_FR: begin
                pat = 32'(cacbs_pkg::PAT_FR);         len = 2;
            end
            cacbs_pkg::CMD_SCAN: begin
                pat = 32'(cacbs_pkg::PAT_SCAN);       len = 2;
            end
            default: begin
                pat = 32'(cacbs_pkg::PAT_RANDOM);     len = 2;
            end
        endcase
        upto = broken ? int'($urandom_range(1, len - 1)) : len;
        for (int i = 0; i < upto; i++)
            send_host_byte(pat[8 * (len - 1 - i) +: 8], 1'b0, '0);
        if (broken) send_host_byte(8'($urandom_range(0, 255)), 1'b0, '0);
    endtask

    // Mostly well-formed commands with random filler, some broken ones and raw noise
    task automatic send_random_burst();
        logic [3:0] cmd;
        int         kind;
        kind = $urandom_range(0, 9);
        cmd  = 4'($urandom_range(cacbs_pkg::CMD_INIT, cacbs_pkg::CMD_RANDOM));
        if (pend_cmd == cacbs_pkg::CMD_INIT && $urandom_range(0, 2) == 0)
            send_host_byte(dev_id, 1'b0, '0);
        if (kind <= 5) begin
            repeat ($urandom_range(0, 2))
                send_host_byte(8'($urandom_range(0, 255)), 1'b0, '0);
            send_command(cmd, 1'b0);
            if (cmd == cacbs_pkg::CMD_INIT && $urandom_range(0, 3) != 0) begin
                repeat ($urandom_range(0, 2))
                    send_host_byte(8'($urandom_range(0, 255)), 1'b0, '0);
                send_host_byte(dev_id, 1'b0, '0);
            end
        end else if (kind <= 7) begin
            send_command(cmd, 1'b1);
        end else if (kind == 8) begin
            send_host_byte(8'($urandom_range(0, 255)), 1'b0, '0);
        end else begin
            repeat ($urandom_range(1, 6))
                drive_edge(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0, '0);
        end
    endtask

    // Stop offering edges and wait until every expected result is back
    task automatic drain_results();
        @(negedge clk);
        edge_if.valid <= 1'b0;
        while (exp_results.size() != 0) @(posedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // Write the device id register while the bus is idle
    task automatic write_device_id(input logic [7:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        dev_id  = value;
    endtask

    // ------------------------------------------------------------- checking

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            fail_cnt++;
        end
    endtask

    // Compare each result transaction with the oldest expectation
    always @(posedge clk) begin
        cacbs_pkg::t_result want;
        if (rst_n && result_if.valid && result_if.ready) begin
            if (exp_results.size() == 0) begin
                $error("result transaction with no expectation pending");
                fail_cnt++;
            end else begin
                want = exp_results.pop_front();
                check_field("drive_enable", 8'(want.drive_enable),
                            8'(result_if.payload.drive_enable));
                check_field("drive_level", 8'(want.drive_level),
                            8'(result_if.payload.drive_level));
                check_field("byte_valid", 8'(want.byte_valid),
                            8'(result_if.payload.byte_valid));
                check_field("byte_value", want.byte_value, result_if.payload.byte_value);
                check_field("event_code", 8'(want.event_code),
                            8'(result_if.payload.event_code));
                check_field("track_number", want.track_number,
                            result_if.payload.track_number);
                check_field("stopped", 8'(want.stopped), 8'(result_if.payload.stopped));
            end
        end
    end

    // Drop result ready in short random bursts, or for one long hold on request
    always begin
        @(negedge clk);
        if (long_hold_req) begin
            result_if.ready <= 1'b0;
            hold_cnt = 0;
            while (hold_cnt < LONG_HOLD) begin
                @(negedge clk);
                hold_cnt++;
            end
            long_hold_req = 1'b0;
        end else if (!no_idle && rst_n && $urandom_range(0, 4) == 0) begin
            result_if.ready <= 1'b0;
            repeat ($urandom_range(0, 2)) @(negedge clk);
        end else begin
            result_if.ready <= 1'b1;
        end
    end

    // Abort when no transaction moves on either channel for too long
    always @(posedge clk) begin
        if (!rst_n || (edge_if.valid && edge_if.ready) || (result_if.valid && result_if.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("car_audio_changer_bus_slave_unit regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------- sequence

    initial begin
        logic [7:0]         id;
        cacbs_pkg::t_result row_res;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_wdata       = 8'h00;
        edge_if.valid   = 1'b0;
        edge_if.payload = '0;
        result_if.ready = 1'b0;

        // Reset the model along with the block
        for (int i = 0; i < WIN; i++) win[i] = cacbs_pkg::IDLE_BYTE;
        rx_sr       = 8'h00;
        rx_idx      = 3'd7;
        tx_idx      = 3'd7;
        tx_sr       = 8'h00;
        tx_active   = 1'b0;
        pend_cmd    = cacbs_pkg::CMD_NONE;
        resp_idx    = 4'd0;
        stop_flag   = 1'b0;
        status_byte = cacbs_pkg::STATUS_STOPPED;
        track       = cacbs_pkg::TRACK_FIRST;
        host_evt    = cacbs_pkg::EVT_NONE;
        drv_on      = 1'b0;
        drv_lvl     = 1'b0;
        dev_id      = cacbs_pkg::DEVICE_ID_RESET;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // Walk the directed table with the reset device id
        for (int r = 0; r < DIR_ROWS; r++) begin
            row_res = cacbs_pkg::t_result'{
                drive_enable: 1'b0,
                drive_level:  1'b0,
                byte_valid:   1'b1,
                byte_value:   dir_rows[r].data,
                event_code:   dir_rows[r].evt,
                track_number: dir_rows[r].trk,
                stopped:      dir_rows[r].stp
            };
            send_host_byte(dir_rows[r].data, dir_rows[r].typed, row_res);
        end
        flush_bus();
        drain_results();

        // Random phases, one device id each; long result hold in the second,
        // no idling in the last
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       id = 8'h00;
                1:       id = 8'hFF;
                default: id = 8'($urandom_range(0, 255));
            endcase
            write_device_id(id);
            if (p == 1) long_hold_req = 1'b1;
            if (p == PHASES - 1) no_idle = 1'b1;
            edges_done = 0;
            while (edges_done < RANDOM_EDGES / PHASES) send_random_burst();
            flush_bus();
            drain_results();
        end

        if (fail_cnt == 0)
            $display("car_audio_changer_bus_slave_unit regression: pass");
        else
            $display("car_audio_changer_bus_slave_unit regression: fail");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/cacbs_pkg.sv
hw/rtl/cacbs_chan_if.sv
hw/rtl/car_audio_changer_bus_slave_unit.sv
hw/rtl/cacbs_checker.sv
test/tb_car_audio_changer_bus_slave_unit.sv
